FILE: rtl/core/cad_pkg.sv
// Shared widths, constants and types of the calendar age block.
package cad_pkg;

    localparam int DATE_W = 27;
    localparam int TIME_W = 18;
    localparam int AGE_W  = 22;
    localparam int DAYS_W = 24;
    localparam int DEPTH  = 7;

    localparam logic [30:0] DIV100_MUL   = 31'd1374389535;
    localparam int          DIV100_SHIFT = 37;
    localparam logic [13:0] DIV400_MUL   = 14'd10486;
    localparam logic [13:0] DIV5_MUL     = 14'd13108;
    localparam logic [5:0]  DIV100S_MUL  = 6'd41;

    localparam logic signed [15:0] YEARS_PER_ERA = 16'sd400;
    localparam logic signed [23:0] ERA_DAYS      = 24'sd146097;
    localparam logic signed [23:0] EPOCH_SHIFT   = 24'sd719468;
    localparam logic [AGE_W-1:0]   AGE_MAX       = {AGE_W{1'b1}};

    typedef logic signed [DAYS_W-1:0] t_days;

endpackage

FILE: rtl/core/cad_in_if.sv
// Input channel: record and current clock reading, with valid and ready.
interface cad_in_if;
    logic                        valid;
    logic                        ready;
    logic                        record_present;
    logic                        record_has_time;
    logic [cad_pkg::DATE_W-1:0]  record_date;
    logic [cad_pkg::TIME_W-1:0]  record_time;
    logic                        clock_valid;
    logic [cad_pkg::DATE_W-1:0]  now_date;
    logic [cad_pkg::TIME_W-1:0]  now_time;

    modport source (
        output valid, record_present, record_has_time, record_date, record_time,
               clock_valid, now_date, now_time,
        input  ready
    );
    modport sink (
        input  valid, record_present, record_has_time, record_date, record_time,
               clock_valid, now_date, now_time,
        output ready
    );
endinterface

FILE: rtl/core/cad_out_if.sv
// Output channel: clock-went-back flag and age in days, with valid and ready.
interface cad_out_if;
    logic                       valid;
    logic                       ready;
    logic                       clock_went_back;
    logic                       age_valid;
    logic [cad_pkg::AGE_W-1:0]  age_days;

    modport source (
        output valid, clock_went_back, age_valid, age_days,
        input  ready
    );
    modport sink (
        input  valid, clock_went_back, age_valid, age_days,
        output ready
    );
endinterface

FILE: rtl/core/cad_days.sv
// Seven-stage pipeline that turns a decimal yyyymmdd date into days since 1970-01-01.
module cad_days (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cad_pkg::DATE_W-1:0]  i_date,
    output cad_pkg::t_days              o_days
);

    logic [57:0] w_p1;
    logic [26:0] r_s1_x;
    logic [20:0] r_s1_q1;

    logic [26:0] w_q1x100;
    logic [51:0] w_p2;
    logic [6:0]  r_s2_day;
    logic [20:0] r_s2_q1;
    logic [13:0] r_s2_q2;

    logic [20:0] w_q2x100;
    logic [6:0]  w_mon;
    logic signed [14:0] r_s3_ya;
    logic [6:0]         r_s3_mp;
    logic [6:0]         r_s3_day;

    logic [27:0]        w_p4;
    logic signed [14:0] r_s4_ya;
    logic signed [6:0]  r_s4_era;
    logic [13:0]        r_s4_t;
    logic [6:0]         r_s4_day;

    logic signed [15:0] w_yoe16;
    logic [27:0]        w_p5;
    logic [8:0]         r_s5_yoe;
    logic signed [12:0] r_s5_doy;
    logic signed [6:0]  r_s5_era;

    logic [17:0]        w_yoe365;
    logic [14:0]        w_p6;
    logic signed [18:0] w_doe;
    logic signed [18:0] r_s6_doe;
    cad_pkg::t_days     r_s6_era_days;

    cad_pkg::t_days     r_s7_days;

    assign w_p1 = 58'(i_date) * 58'(cad_pkg::DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_x  <= i_date;
            r_s1_q1 <= w_p1[57:cad_pkg::DIV100_SHIFT];
        end
    end

    assign w_q1x100 = 27'(r_s1_q1) * 27'd100;
    assign w_p2     = 52'(r_s1_q1) * 52'(cad_pkg::DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_day <= 7'(r_s1_x - w_q1x100);
            r_s2_q1  <= r_s1_q1;
            r_s2_q2  <= w_p2[50:cad_pkg::DIV100_SHIFT];
        end
    end

    assign w_q2x100 = 21'(r_s2_q2) * 21'd100;
    assign w_mon    = 7'(r_s2_q1 - w_q2x100);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_ya  <= $signed({1'b0, r_s2_q2}) - ((w_mon <= 7'd2) ? 15'sd1 : 15'sd0);
            r_s3_mp  <= (w_mon > 7'd2) ? (w_mon - 7'd3) : (w_mon + 7'd9);
            r_s3_day <= r_s2_day;
        end
    end

    assign w_p4 = 28'(r_s3_ya[13:0]) * 28'(cad_pkg::DIV400_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_ya  <= r_s3_ya;
            r_s4_era <= r_s3_ya[14] ? -7'sd1 : $signed({1'b0, w_p4[27:22]});
            r_s4_t   <= 14'(14'(r_s3_mp) * 14'd153 + 14'd2);
            r_s4_day <= r_s3_day;
        end
    end

    assign w_yoe16 = 16'(r_s4_ya) - 16'(r_s4_era) * cad_pkg::YEARS_PER_ERA;
    assign w_p5    = 28'(r_s4_t) * 28'(cad_pkg::DIV5_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_yoe <= w_yoe16[8:0];
            r_s5_doy <= $signed({1'b0, w_p5[27:16]}) + $signed({6'b0, r_s4_day})
                        - 13'sd1;
            r_s5_era <= r_s4_era;
        end
    end

    assign w_yoe365 = 18'(r_s5_yoe) * 18'd365;
    assign w_p6     = 15'(r_s5_yoe) * 15'(cad_pkg::DIV100S_MUL);
    assign w_doe    = $signed({1'b0, w_yoe365}) + $signed({12'b0, r_s5_yoe[8:2]})
                      - $signed({17'b0, w_p6[13:12]}) + 19'(r_s5_doy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_doe      <= w_doe;
            r_s6_era_days <= cad_pkg::t_days'(24'(r_s5_era) * cad_pkg::ERA_DAYS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s7_days <= r_s6_era_days + 24'(r_s6_doe) - cad_pkg::EPOCH_SHIFT;
        end
    end

    assign o_days = r_s7_days;

endmodule

FILE: rtl/core/calendar_age_in_days.sv
// Top level: age of a stored record in whole days against the current clock reading.
//
// Usage:
//   i_in carries one item per handshake: record present and has-time flags,
//   record date (yyyymmdd) and time (hhmmss), clock valid flag, current date
//   and time. o_out returns one item per input item: clock_went_back,
//   age_valid and age_days, in input order.
//   Throughput is one item per cycle while o_out does not stall; the depth is
//   set by the two decimal splits by 100, the era split by 400 and the
//   day-of-era sum, each on its own register stage, plus the output register.
//   Both dates go through twin day-count pipelines side by side.
//   Reset clears all stage valid bits; o_out.valid is low afterwards and
//   i_in.ready is high.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and i_in.ready drops; nothing is lost or repeated.
//   An age beyond the field saturates at all ones with age_valid set.
module calendar_age_in_days (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cad_in_if.sink            i_in,
    cad_out_if.source         o_out
);

    logic                         w_en;
    logic [cad_pkg::DEPTH-1:0]    r_vld;
    logic [cad_pkg::DEPTH-1:0]    r_gate;
    logic [cad_pkg::DEPTH-1:0]    r_back;
    logic                         w_back;
    logic                         w_gate;

    cad_pkg::t_days               w_days_now;
    cad_pkg::t_days               w_days_rec;
    logic signed [cad_pkg::DAYS_W:0] w_diff;

    logic                         r_out_vld;
    logic                         r_out_back;
    logic                         r_out_age_valid;
    logic [cad_pkg::AGE_W-1:0]    r_out_age;
    logic                         n_out_back;
    logic                         n_out_age_valid;
    logic [cad_pkg::AGE_W-1:0]    n_out_age;

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    assign w_gate = i_in.record_present && i_in.record_has_time && i_in.clock_valid;
    assign w_back = (i_in.now_date < i_in.record_date) ||
                    ((i_in.now_date == i_in.record_date) &&
                     (i_in.now_time < i_in.record_time));

    cad_days u_days_now (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_date (i_in.now_date),
        .o_days (w_days_now)
    );

    cad_days u_days_rec (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_date (i_in.record_date),
        .o_days (w_days_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[cad_pkg::DEPTH-2:0], i_in.valid};
            r_out_vld <= r_vld[cad_pkg::DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gate <= {r_gate[cad_pkg::DEPTH-2:0], w_gate};
            r_back <= {r_back[cad_pkg::DEPTH-2:0], w_back};
        end
    end

    assign w_diff = (cad_pkg::DAYS_W+1)'(w_days_now) - (cad_pkg::DAYS_W+1)'(w_days_rec);

    always_comb begin
        n_out_back      = 1'b0;
        n_out_age_valid = 1'b0;
        n_out_age       = '0;
        priority if (!r_gate[cad_pkg::DEPTH-1]) begin
            n_out_back = 1'b0;
        end else if (r_back[cad_pkg::DEPTH-1]) begin
            n_out_back = 1'b1;
        end else if (!w_diff[cad_pkg::DAYS_W]) begin
            n_out_age_valid = 1'b1;
            n_out_age       = (w_diff > $signed({3'b0, cad_pkg::AGE_MAX})) ?
                              cad_pkg::AGE_MAX : w_diff[cad_pkg::AGE_W-1:0];
        end else begin
            n_out_age_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_back      <= n_out_back;
            r_out_age_valid <= n_out_age_valid;
            r_out_age       <= n_out_age;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.clock_went_back = r_out_back;
    assign o_out.age_valid       = r_out_age_valid;
    assign o_out.age_days        = r_out_age;

endmodule

FILE: verif/calendar_age_in_days_tb.sv
`timescale 1ns / 100ps
// Testbench for calendar_age_in_days: directed and random readings checked against a predictor.
module calendar_age_in_days_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 32;
    localparam int RANDOM_ITEMS = 675;
    localparam int LONG_HOLD = 400;

    typedef logic [cad_pkg::DATE_W-1:0] t_date;
    typedef logic [cad_pkg::TIME_W-1:0] t_hms;
    typedef logic [cad_pkg::AGE_W-1:0]  t_age_days;

    typedef struct {
        logic  present;
        logic  has_time;
        t_date rec_date;
        t_hms  rec_hms;
        logic  clk_ok;
        t_date now_date;
        t_hms  now_hms;
    } t_reading;

    typedef struct {
        logic      went_back;
        logic      age_ok;
        t_age_days age;
    } t_age;

    logic clk;
    logic rst_n;

    cad_in_if  in_ch ();
    cad_out_if out_ch ();

    calendar_age_in_days u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_age   pending_ages[$];
    t_age   want;
    int     mismatches = 0;
    int     cycle_count = 0;
    int     rx_hold_cycles = 0;
    bit     tx_steady = 0;
    bit     rx_steady = 0;

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint days_from_civil(input t_date ymd);
        longint v;
        longint yr;
        longint mo;
        longint dy;
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        v = ymd;
        yr = v / 10000;
        mo = (v / 100) % 100;
        dy = v % 100;
        if (mo <= 2) begin
            yr = yr - 1;
        end
        era = (yr >= 0 ? yr : yr - 399) / 400;
        yoe = yr - era * 400;
        mp = mo + (mo > 2 ? -3 : 9);
        doy = (153 * mp + 2) / 5 + dy - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic t_age predict_age(input t_reading r);
        t_age             a;
        longint unsigned  rec_stamp;
        longint unsigned  now_stamp;
        longint           diff;
        a.went_back = 1'b0;
        a.age_ok = 1'b0;
        a.age = '0;
        if (r.present && r.has_time && r.clk_ok) begin
            rec_stamp = r.rec_date;
            rec_stamp = rec_stamp * 1000000 + r.rec_hms;
            now_stamp = r.now_date;
            now_stamp = now_stamp * 1000000 + r.now_hms;
            if (now_stamp < rec_stamp) begin
                a.went_back = 1'b1;
            end else begin
                diff = days_from_civil(r.now_date) - days_from_civil(r.rec_date);
                if (diff >= 0) begin
                    a.age_ok = 1'b1;
                    a.age = (diff > longint'(cad_pkg::AGE_MAX)) ?
                            cad_pkg::AGE_MAX : t_age_days'(diff);
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_ages.size() == 0) begin
                report_mismatch("unexpected item, age_days", out_ch.age_days, 0);
            end else begin
                want = pending_ages.pop_front();
                if (out_ch.clock_went_back !== want.went_back) begin
                    report_mismatch("clock_went_back", out_ch.clock_went_back, want.went_back);
                end
                if (out_ch.age_valid !== want.age_ok) begin
                    report_mismatch("age_valid", out_ch.age_valid, want.age_ok);
                end
                if (out_ch.age_days !== want.age) begin
                    report_mismatch("age_days", out_ch.age_days, want.age);
                end
            end
        end
    end

    initial begin : rx_proc
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    task automatic send_reading(input t_reading r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.record_present  <= r.present;
        in_ch.record_has_time <= r.has_time;
        in_ch.record_date     <= r.rec_date;
        in_ch.record_time     <= r.rec_hms;
        in_ch.clock_valid     <= r.clk_ok;
        in_ch.now_date        <= r.now_date;
        in_ch.now_time        <= r.now_hms;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_ages.push_back(predict_age(r));
    endtask

    task automatic send_dates(input int rd, input int rt, input int nd, input int nt);
        t_reading r;
        r = '{1'b1, 1'b1, t_date'(rd), t_hms'(rt), 1'b1, t_date'(nd), t_hms'(nt)};
        send_reading(r);
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_ages.size() != 0) @(posedge clk);
    endtask

    function automatic t_date random_date();
        int y;
        int m;
        int d;
        if ($urandom_range(0, 4) == 0) begin
            return t_date'($urandom_range(0, 99991231));
        end
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(1900, 2100);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 31 : 28);
        return t_date'(y * 10000 + m * 100 + d);
    endfunction

    function automatic t_hms random_hms();
        if ($urandom_range(0, 3) == 0) begin
            return t_hms'($urandom_range(0, 235959));
        end
        return t_hms'($urandom_range(0, 23) * 10000 + $urandom_range(0, 59) * 100
                      + $urandom_range(0, 59));
    endfunction

    function automatic t_reading random_reading();
        t_reading r;
        t_date    a;
        t_date    b;
        int       pick;
        r.present = ($urandom_range(0, 19) != 0);
        r.has_time = ($urandom_range(0, 19) != 0);
        r.clk_ok = ($urandom_range(0, 19) != 0);
        a = random_date();
        b = random_date();
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            b = a;
        end else if (pick < 8 && b < a) begin
            b = a;
            a = random_date();
            if (a > b) begin
                {a, b} = {b, a};
            end
        end
        r.rec_date = a;
        r.now_date = b;
        r.rec_hms = random_hms();
        r.now_hms = random_hms();
        return r;
    endfunction

    task automatic test_gating();
        t_reading r;
        for (int i = 0; i < 8; i++) begin
            r = '{i[0], i[1], t_date'(20200101), t_hms'(0), i[2],
                  t_date'(20240615), t_hms'(120000)};
            send_reading(r);
        end
    endtask

    task automatic test_calendar_edges();
        send_dates(0, 0, 99991231, 235959);
        send_dates(99991231, 235959, 99991231, 235959);
        send_dates(99991231, 235959, 0, 0);
        send_dates(20240301, 120000, 20240301, 115959);
        send_dates(19700101, 0, 19700102, 0);
        send_dates(20000228, 0, 20000301, 0);
        send_dates(19000228, 0, 19000301, 0);
        send_dates(0, 0, 0, 235959);
    endtask

    task automatic test_malformed_dates();
        send_dates(100, 0, 300, 0);
        send_dates(20201399, 0, 20210000, 0);
        send_dates(20200199, 0, 20200200, 0);
        send_dates(20209999, 0, 20210101, 0);
        send_dates(5000000, 100, 5000000, 200);
    endtask

    task automatic test_output_stall();
        wait_results_drained();
        tx_steady = 1;
        rx_hold_cycles = LONG_HOLD;
        repeat (60) send_reading(random_reading());
        tx_steady = 0;
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int seg;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 75 == 0) begin
                seg = i / 75;
                tx_steady = (seg % 3 == 1);
                rx_steady = (seg % 3 == 2) || (seg % 4 == 3);
            end
            if (i % 200 == 199) begin
                wait_results_drained();
            end
            send_reading(random_reading());
        end
        tx_steady = 0;
        rx_steady = 0;
    endtask

    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.record_present = 1'b0;
        in_ch.record_has_time = 1'b0;
        in_ch.record_date = '0;
        in_ch.record_time = '0;
        in_ch.clock_valid = 1'b0;
        in_ch.now_date = '0;
        in_ch.now_time = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gating();
        test_calendar_edges();
        test_malformed_dates();
        test_output_stall();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_ages.size() != 0) begin
            report_mismatch("items never returned", 0, pending_ages.size());
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
